// ===== rtl/core/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

	// built depth and register reset
	localparam int DEPTH_DEF = 16;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic [1:0] FN_ENQ = 2'd0;
	localparam logic [1:0] FN_DEQ = 2'd1;
	localparam logic [1:0] FN_QRY = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic signed [31:0] VALUE_NONE = -32'sd1;

	typedef struct packed {
		logic [1:0] func;
		logic signed [31:0] item_value;
		logic signed [31:0] item_priority;
	} spq_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] out_value;
		logic signed [31:0] out_priority;
		logic is_empty;
		logic is_full;
	} spq_out_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} spq_entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic enq;
		logic deq;
		spq_entry_t new_entry;
	} spq_cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
`default_nettype none
module spq_cell (
	input wire logic clk,
	input wire spq_pkg::spq_cell_ctl_t ctl,
	input wire logic occupied,
	input wire logic left_ins,
	input wire spq_pkg::spq_entry_t left_entry,
	input wire spq_pkg::spq_entry_t right_entry,
	output logic ins,
	output spq_pkg::spq_entry_t entry
);

	spq_pkg::spq_entry_t entry_q;

	// new entry belongs at or before this cell (ties stay ahead)
	always_comb begin
		ins = !occupied || (entry_q.prio > ctl.new_entry.prio);
	end

	// insert: first cell past the slot takes the new entry, the rest shift right
	// remove: every cell takes its right neighbour
	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (ins && !left_ins) begin
				entry_q <= ctl.new_entry;
			end else if (ins) begin
				entry_q <= left_entry;
			end
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_priority_queue_unit.sv =====
`default_nettype none
// channel  direction  payload              handshake
// cfg      in         cfg_data (capacity)  cfg_valid / cfg_ready
// in       in         in_data  (spq_in_t)  in_valid / in_ready
// out      out        out_data (spq_out_t) out_valid / out_ready
//
// one item per cycle while in_ready is high: every cell compares its priority with the
// incoming one in parallel and the row shifts in the cycle the item is accepted
// the result is held in an output register; in_ready drops only while a
// result waits and out_ready is low
// reset empties the queue, sets capacity to 16 and clears the output valid
module sorted_priority_queue_unit #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [spq_pkg::CAP_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire spq_pkg::spq_in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output spq_pkg::spq_out_t out_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

	logic [spq_pkg::CAP_W-1:0] capacity_q;
	logic [CW-1:0] count_q;
	logic out_valid_q;
	spq_pkg::spq_out_t out_data_q;

	logic fire;
	logic [XW-1:0] cap_x;
	logic [XW-1:0] cap_eff;
	logic [XW-1:0] count_x;
	logic [XW-1:0] count_nx;
	logic full_now;
	logic empty_now;
	logic enq_ok;
	logic deq_ok;
	logic [CW-1:0] count_d;
	spq_pkg::spq_out_t res;
	spq_pkg::spq_cell_ctl_t ctl;

	logic ins [DEPTH];
	spq_pkg::spq_entry_t entries [DEPTH];

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign fire = in_valid && in_ready;

	// capacity in effect and flags before the operation
	always_comb begin
		cap_x = XW'(capacity_q);
		cap_eff = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
		count_x = XW'(count_q);
		full_now = count_x >= cap_eff;
		empty_now = count_q == '0;
		enq_ok = fire && (in_data.func == spq_pkg::FN_ENQ) && !full_now;
		deq_ok = fire && (in_data.func == spq_pkg::FN_DEQ) && !empty_now;
	end

	// next count and result item
	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + CW'(1);
		end else if (deq_ok) begin
			count_d = count_q - CW'(1);
		end
		count_nx = XW'(count_d);
		res.status = spq_pkg::ST_OK;
		res.out_value = '0;
		res.out_priority = '0;
		if (in_data.func == spq_pkg::FN_ENQ) begin
			if (full_now) begin
				res.status = spq_pkg::ST_OVERFLOW;
			end
		end else if (in_data.func == spq_pkg::FN_DEQ) begin
			if (empty_now) begin
				res.status = spq_pkg::ST_UNDERFLOW;
				res.out_value = spq_pkg::VALUE_NONE;
			end else begin
				res.out_value = entries[0].value;
				res.out_priority = entries[0].prio;
			end
		end
		res.is_empty = count_d == '0;
		res.is_full = count_nx >= cap_eff;
	end

	// broadcast to the cell row
	always_comb begin
		ctl.enq = enq_ok;
		ctl.deq = deq_ok;
		ctl.new_entry.value = in_data.item_value;
		ctl.new_entry.prio = in_data.item_priority;
	end

	// row of cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic left_ins;
		spq_pkg::spq_entry_t left_entry;
		spq_pkg::spq_entry_t right_entry;
		logic occupied;

		assign occupied = CW'(i) < count_q;
		if (i == 0) begin : g_head
			assign left_ins = 1'b0;
			assign left_entry = ctl.new_entry;
		end else begin : g_body
			assign left_ins = ins[i-1];
			assign left_entry = entries[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_entry = entries[i];
		end else begin : g_mid
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.occupied(occupied),
			.left_ins(left_ins),
			.left_entry(left_entry),
			.right_entry(right_entry),
			.ins(ins[i]),
			.entry(entries[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= spq_pkg::CAP_RESET;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
`default_nettype none
module spq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire spq_pkg::spq_out_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every accepted item gives a result next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// underflow returns the fixed empty answer
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == spq_pkg::ST_UNDERFLOW |->
		out_data.out_value == spq_pkg::VALUE_NONE && out_data.out_priority == '0 &&
		out_data.is_empty)
		else $error("bad underflow result");

	// overflow only on a full queue, nothing returned
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == spq_pkg::ST_OVERFLOW |->
		out_data.is_full && out_data.out_value == '0 && out_data.out_priority == '0)
		else $error("bad overflow result");

	// status never takes the unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == spq_pkg::ST_OK ||
		out_data.status == spq_pkg::ST_OVERFLOW ||
		out_data.status == spq_pkg::ST_UNDERFLOW)
		else $error("unused status code");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
`default_nettype wire
